/* hdl/tmcg_pkg.sv */
// Shared constants, codes and types for the text-mode character generator.
// No dependencies; every other file refers to this package by scoped names.
package tmcg_pkg;

    // Screen geometry
    localparam int TEXT_COLUMNS = 64;
    localparam int TEXT_ROWS    = 16;
    localparam int GLYPH_LINES  = 16;

    localparam int GLYPH_STRIDE_W = 4;     // glyphs sit 16 bytes apart
    localparam int CODE_W         = 7;     // displayed part of a character code
    localparam int GLYPH_BYTES    = 2048;
    localparam int GLYPH_AW       = 11;
    localparam logic [2:0] LEFT_IDX = 3'd7; // MSB is the leftmost pixel

    localparam int CHAR_CELLS = TEXT_COLUMNS * TEXT_ROWS;
    localparam int CELL_W     = (CHAR_CELLS > 1) ? $clog2(CHAR_CELLS) : 1;
    localparam int COL_W      = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
    localparam int ROW_W      = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
    localparam int LINE_W     = $clog2(GLYPH_LINES);
    localparam int SCREEN_H   = TEXT_ROWS * GLYPH_LINES;
    localparam int SY_W       = $clog2(SCREEN_H);

    // Clear pass covers the larger of the two stores
    localparam int CLR_N = (CHAR_CELLS > GLYPH_BYTES) ? CHAR_CELLS : GLYPH_BYTES;
    localparam int CLR_W = $clog2(CLR_N);

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;
    localparam int CREDIT_W   = 4;

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int ADDRESS_W = 11;
    localparam int DATA_W    = 8;
    localparam int PIX_X_W   = 9;
    localparam int PIX_Y_W   = 8;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CHAR_WR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GLYPH_WR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

    typedef struct packed {
        logic [CELL_W-1:0]  cell_idx;
        logic [LINE_W-1:0]  line;
        logic [2:0]         bit_idx;
        logic [PIX_X_W-1:0] x;
        logic [PIX_Y_W-1:0] y;
        logic               last;
    } t_scan_pos;

    typedef struct packed {
        logic               on;
        logic [PIX_X_W-1:0] x;
        logic [PIX_Y_W-1:0] y;
        logic               last;
    } t_pixel;

    typedef struct packed {
        logic busy;
        logic s1_valid;
        logic s2_valid;
    } t_pipe_status;

endpackage

/* hdl/tmcg_in_if.sv */
// Input channel of the character generator: handshake plus action, address, data.
// Depends on tmcg_pkg for field widths.
interface tmcg_in_if;
    logic                           valid;
    logic                           ready;
    logic [tmcg_pkg::ACTION_W-1:0]  action;
    logic [tmcg_pkg::ADDRESS_W-1:0] address;
    logic [tmcg_pkg::DATA_W-1:0]    data;

    modport source (output valid, output action, output address, output data, input ready);
    modport sink   (input valid, input action, input address, input data, output ready);
endinterface

/* hdl/tmcg_out_if.sv */
// Output channel of the character generator: handshake plus one pixel result.
// Depends on tmcg_pkg for field widths.
interface tmcg_out_if;
    logic                         valid;
    logic                         ready;
    logic                         pixel_on;
    logic [tmcg_pkg::PIX_X_W-1:0] pixel_x;
    logic [tmcg_pkg::PIX_Y_W-1:0] pixel_y;
    logic                         frame_last;

    modport source (output valid, output pixel_on, output pixel_x, output pixel_y,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_on, input pixel_x, input pixel_y,
                    input frame_last, output ready);
endinterface

/* hdl/tmcg_scan.sv */
// Raster scan counters: bit, column, glyph line, row and line number.
// Depends on tmcg_pkg.
module tmcg_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    output tmcg_pkg::t_scan_pos o_pos
);
    logic [2:0]                     r_bit, n_bit;
    logic [tmcg_pkg::COL_W-1:0]     r_col, n_col;
    logic [tmcg_pkg::LINE_W-1:0]    r_line, n_line;
    logic [tmcg_pkg::ROW_W-1:0]     r_row, n_row;
    logic [tmcg_pkg::SY_W-1:0]      r_y, n_y;
    logic                           end_bit, end_col, end_line, end_row;
    logic [31:0]                    x_full, y_full, cell_full;

    assign end_bit  = (r_bit == tmcg_pkg::LEFT_IDX);
    assign end_col  = (r_col == tmcg_pkg::COL_W'(tmcg_pkg::TEXT_COLUMNS - 1));
    assign end_line = (r_line == tmcg_pkg::LINE_W'(tmcg_pkg::GLYPH_LINES - 1));
    assign end_row  = (r_row == tmcg_pkg::ROW_W'(tmcg_pkg::TEXT_ROWS - 1));

    always_comb begin
        n_bit  = r_bit;
        n_col  = r_col;
        n_line = r_line;
        n_row  = r_row;
        n_y    = r_y;
        if (i_advance) begin
            if (!end_bit) begin
                n_bit = r_bit + 3'd1;
            end else begin
                n_bit = '0;
                if (!end_col) begin
                    n_col = r_col + 1'b1;
                end else begin
                    n_col = '0;
                    if (end_line && end_row) begin
                        n_line = '0;
                        n_row  = '0;
                        n_y    = '0;
                    end else if (end_line) begin
                        n_line = '0;
                        n_row  = r_row + 1'b1;
                        n_y    = r_y + 1'b1;
                    end else begin
                        n_line = r_line + 1'b1;
                        n_y    = r_y + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit  <= '0;
            r_col  <= '0;
            r_line <= '0;
            r_row  <= '0;
            r_y    <= '0;
        end else begin
            r_bit  <= n_bit;
            r_col  <= n_col;
            r_line <= n_line;
            r_row  <= n_row;
            r_y    <= n_y;
        end
    end

    // Coordinates are reported masked to the field widths
    assign x_full    = 32'({r_col, r_bit});
    assign y_full    = 32'(r_y);
    assign cell_full = 32'(r_row) * tmcg_pkg::TEXT_COLUMNS + 32'(r_col);

    assign o_pos.cell_idx = cell_full[tmcg_pkg::CELL_W-1:0];
    assign o_pos.line     = r_line;
    assign o_pos.bit_idx  = r_bit;
    assign o_pos.x        = x_full[tmcg_pkg::PIX_X_W-1:0];
    assign o_pos.y        = y_full[tmcg_pkg::PIX_Y_W-1:0];
    assign o_pos.last     = end_bit && end_col && end_line && end_row;

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_pos.last) |=> (r_bit == '0 && r_col == '0 && r_line == '0
                                       && r_row == '0 && r_y == '0))
        else $error("scan did not wrap after the last pixel");
endmodule

/* hdl/tmcg_store.sv */
// Character and glyph stores with the two-stage lookup pipeline and reset clear pass.
// Depends on tmcg_pkg.
module tmcg_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_char_we,
    input  logic                            i_glyph_we,
    input  logic [tmcg_pkg::ADDRESS_W-1:0]  i_address,
    input  logic [tmcg_pkg::DATA_W-1:0]     i_data,
    input  logic                            i_tick,
    input  tmcg_pkg::t_scan_pos             i_pos,
    output tmcg_pkg::t_pipe_status          o_status,
    output logic                            o_pix_valid,
    output tmcg_pkg::t_pixel                o_pix
);
    logic [tmcg_pkg::DATA_W-1:0] char_mem  [tmcg_pkg::CHAR_CELLS];
    logic [tmcg_pkg::DATA_W-1:0] glyph_mem [tmcg_pkg::GLYPH_BYTES];

    logic                           r_busy;
    logic [tmcg_pkg::CLR_W-1:0]     r_clr;
    logic                           r_s1_valid, r_s2_valid;
    tmcg_pkg::t_scan_pos            r_s1_pos, r_s2_pos;
    logic [tmcg_pkg::DATA_W-1:0]    r_char_q, r_glyph_q;

    logic                           char_in_range, clr_char_hit;
    logic [tmcg_pkg::GLYPH_AW-1:0]  glyph_ra;
    logic [2:0]                     pix_idx;

    assign char_in_range = (32'(i_address) < tmcg_pkg::CHAR_CELLS);
    assign clr_char_hit  = (32'(r_clr) < tmcg_pkg::CHAR_CELLS);
    assign glyph_ra      = {r_char_q[tmcg_pkg::CODE_W-1:0],
                            tmcg_pkg::GLYPH_STRIDE_W'(r_s1_pos.line)};

    // Clear pass: one entry of each store per cycle after reset, until that store is covered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == tmcg_pkg::CLR_W'(tmcg_pkg::CLR_N - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (clr_char_hit) begin
                char_mem[r_clr[tmcg_pkg::CELL_W-1:0]] <= '0;
            end
        end else if (i_char_we && char_in_range) begin
            char_mem[tmcg_pkg::CELL_W'(i_address)] <= i_data;
        end
        r_char_q <= char_mem[i_pos.cell_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            glyph_mem[r_clr[tmcg_pkg::GLYPH_AW-1:0]] <= '0;
        end else if (i_glyph_we) begin
            glyph_mem[i_address] <= i_data;
        end
        r_glyph_q <= glyph_mem[glyph_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_tick;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pos <= i_pos;
        r_s2_pos <= r_s1_pos;
    end

    assign pix_idx = tmcg_pkg::LEFT_IDX - r_s2_pos.bit_idx;

    assign o_pix_valid = r_s2_valid;
    assign o_pix.on    = r_glyph_q[pix_idx];
    assign o_pix.x     = r_s2_pos.x;
    assign o_pix.y     = r_s2_pos.y;
    assign o_pix.last  = r_s2_pos.last;

    assign o_status.busy     = r_busy;
    assign o_status.s1_valid = r_s1_valid;
    assign o_status.s2_valid = r_s2_valid;

    a_tick_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |=> ##1 r_s2_valid)
        else $error("tick did not reach the glyph stage two cycles later");

    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !(i_tick || i_char_we || i_glyph_we))
        else $error("item taken during clear pass");
endmodule

/* hdl/tmcg_pix_fifo.sv */
// Small result queue that decouples the lookup pipeline from the output handshake.
// Depends on tmcg_pkg.
module tmcg_pix_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  tmcg_pkg::t_pixel              i_pix,
    input  logic                          i_pop,
    output logic                          o_valid,
    output tmcg_pkg::t_pixel              o_pix,
    output logic [tmcg_pkg::FIFO_CW-1:0]  o_count
);
    tmcg_pkg::t_pixel               r_mem [tmcg_pkg::FIFO_DEPTH];
    logic [tmcg_pkg::FIFO_AW-1:0]   r_wr, r_rd;
    logic [tmcg_pkg::FIFO_CW-1:0]   r_count;
    logic                           do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pix;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_pix   = r_mem[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != tmcg_pkg::FIFO_CW'(tmcg_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");
endmodule

/* hdl/text_mode_character_generator_unit.sv */
// Text-mode character generator, 64 x 16 cells of 8 x 16 glyph pixels.
// Pipeline: a tick item's pixel passes the character-store read, the glyph-store read and
// the queue write, in that order, before it is offered at the output.
// Throughput: one item per cycle; input stalls during the clear pass and while queued plus in-flight pixels
// reach the queue depth of four. Reset: synchronous, active low; then a clear pass
// zeroes both stores, during which no item is accepted.
module text_mode_character_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmcg_in_if.sink     i_in,
    tmcg_out_if.source  o_out
);
    tmcg_pkg::t_scan_pos                scan_pos;
    tmcg_pkg::t_pipe_status             pipe_status;
    tmcg_pkg::t_pixel                   pipe_pix, queue_pix;
    logic                               pipe_pix_valid;
    logic [tmcg_pkg::FIFO_CW-1:0]       queue_count;
    logic [tmcg_pkg::CREDIT_W-1:0]      credit_used;
    logic                               in_accept;
    logic                               tick, char_we, glyph_we;

    // Accept only when the queue has room for every tick still in the pipeline
    // plus this one; writes share the same gate so items stay in order.
    assign credit_used = tmcg_pkg::CREDIT_W'(queue_count)
                       + tmcg_pkg::CREDIT_W'(pipe_status.s1_valid)
                       + tmcg_pkg::CREDIT_W'(pipe_status.s2_valid);
    assign i_in.ready  = !pipe_status.busy
                       && (credit_used < tmcg_pkg::CREDIT_W'(tmcg_pkg::FIFO_DEPTH));
    assign in_accept   = i_in.valid && i_in.ready;

    // Decode the action; the unused code is dropped without a result
    assign char_we  = in_accept && (i_in.action == tmcg_pkg::ACT_CHAR_WR);
    assign glyph_we = in_accept && (i_in.action == tmcg_pkg::ACT_GLYPH_WR);
    assign tick     = in_accept && (i_in.action == tmcg_pkg::ACT_TICK);

    // Advance the raster position on each tick
    tmcg_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (tick),
        .o_pos     (scan_pos)
    );

    // Look up character then glyph line; writes land in the same cycle they are taken
    tmcg_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_we   (char_we),
        .i_glyph_we  (glyph_we),
        .i_address   (i_in.address),
        .i_data      (i_in.data),
        .i_tick      (tick),
        .i_pos       (scan_pos),
        .o_status    (pipe_status),
        .o_pix_valid (pipe_pix_valid),
        .o_pix       (pipe_pix)
    );

    // Hold finished pixels until the sink takes them
    tmcg_pix_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pipe_pix_valid),
        .i_pix   (pipe_pix),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_pix   (queue_pix),
        .o_count (queue_count)
    );

    assign o_out.pixel_on   = queue_pix.on;
    assign o_out.pixel_x    = queue_pix.x;
    assign o_out.pixel_y    = queue_pix.y;
    assign o_out.frame_last = queue_pix.last;
endmodule
